/* sv/prju_pkg.sv */
package prju_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_DISPLAY_SIZE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_X_SCALE      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_Y_SCALE      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ROTATION     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CAM_POS_X    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CAM_POS_Y    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_CAM_POS_Z    = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_PERSPECTIVE  = 3'd7;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_EXTENT = 2'd1;
  localparam logic [1:0] ST_STALE     = 2'd2;
  localparam logic [1:0] ST_NO_SCALE  = 2'd3;

  // Datapath widths
  localparam int unsigned QuatW    = 16;  // one Q1.14 quaternion component
  localparam int unsigned VecW     = 32;  // vector fed to the rotation unit
  localparam int unsigned RotW     = 41;  // rotated vector, holds any quaternion
  localparam int unsigned RotStages = 4;

endpackage

/* sv/prju_div.sv */
module prju_div
  import prju_pkg::*;
#(
  parameter int unsigned QW    = 30,
  parameter int unsigned DW    = 13,
  parameter int unsigned LANES = 2,
  parameter int unsigned SW    = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [LANES-1:0][DW+QW-1:0]       num_i,
  input  logic [LANES-1:0][DW-1:0]          den_i,
  input  logic [SW-1:0]                     side_i,
  output logic                              valid_o,
  output logic [LANES-1:0][QW-1:0]          quot_o,
  output logic [SW-1:0]                     side_o
);

  // One quotient bit per stage; the caller keeps num below den times 2^QW
  logic                           vld_q  [QW];
  logic [SW-1:0]                  side_q [QW];
  logic [LANES-1:0][DW-1:0]       rem_q  [QW];
  logic [LANES-1:0][DW-1:0]       den_q  [QW];
  logic [LANES-1:0][QW-1:0]       quo_q  [QW];
  logic [LANES-1:0][QW-1:0]       low_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic                     vld_in;
    logic [SW-1:0]            side_in;
    logic [LANES-1:0][DW-1:0] rem_in, den_in, rem_d;
    logic [LANES-1:0][QW-1:0] quo_in, low_in, quo_d, low_d;

    if (k == 0) begin : g_head
      always_comb begin
        vld_in  = valid_i;
        side_in = side_i;
        den_in  = den_i;
        quo_in  = '0;
        for (int unsigned l = 0; l < LANES; l++) begin
          rem_in[l] = num_i[l][DW+QW-1:QW];
          low_in[l] = num_i[l][QW-1:0];
        end
      end
    end else begin : g_tail
      always_comb begin
        vld_in  = vld_q[k-1];
        side_in = side_q[k-1];
        den_in  = den_q[k-1];
        quo_in  = quo_q[k-1];
        rem_in  = rem_q[k-1];
        low_in  = low_q[k-1];
      end
    end

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
      logic [DW:0] trial;
      logic [DW:0] diff;
      for (int unsigned l = 0; l < LANES; l++) begin
        trial    = {rem_in[l], low_in[l][QW-1]};
        diff     = trial - {1'b0, den_in[l]};
        rem_d[l] = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
        quo_d[l] = {quo_in[l][QW-2:0], ~diff[DW]};
        low_d[l] = low_in[l] << 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_in;
      den_q[k]  <= den_in;
      rem_q[k]  <= rem_d;
      quo_q[k]  <= quo_d;
      low_q[k]  <= low_d;
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

/* sv/prju_sqrt.sv */
module prju_sqrt
  import prju_pkg::*;
#(
  parameter int unsigned OW = 32,
  parameter int unsigned SW = 66
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [2*OW-1:0] rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [OW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  localparam int unsigned IW = 2 * OW;

  // One root bit per stage, two radicand bits consumed each step
  logic            vld_q  [OW];
  logic [SW-1:0]   side_q [OW];
  logic [OW:0]     rem_q  [OW];
  logic [OW-1:0]   root_q [OW];
  logic [IW-1:0]   low_q  [OW];

  for (genvar k = 0; k < OW; k++) begin : g_step
    logic          vld_in;
    logic [SW-1:0] side_in;
    logic [OW:0]   rem_in, rem_d;
    logic [OW-1:0] root_in, root_d;
    logic [IW-1:0] low_in;
    logic [OW+2:0] trial, test, diff;

    if (k == 0) begin : g_head
      assign vld_in  = valid_i;
      assign side_in = side_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign low_in  = rad_i;
    end else begin : g_tail
      assign vld_in  = vld_q[k-1];
      assign side_in = side_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign low_in  = low_q[k-1];
    end

    // Try root*4+1 against the remainder with two new radicand bits
    assign trial  = {rem_in, low_in[IW-1:IW-2]};
    assign test   = {1'b0, root_in, 2'b01};
    assign diff   = trial - test;
    assign rem_d  = diff[OW+2] ? trial[OW:0] : diff[OW:0];
    assign root_d = {root_in[OW-2:0], ~diff[OW+2]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_in;
      rem_q[k]  <= rem_d;
      root_q[k] <= root_d;
      low_q[k]  <= low_in << 2;
    end
  end

  assign valid_o = vld_q[OW-1];
  assign root_o  = root_q[OW-1];
  assign side_o  = side_q[OW-1];

endmodule

/* sv/prju_rot.sv */
module prju_rot
  import prju_pkg::*;
#(
  parameter int unsigned LANES = 2,
  parameter int unsigned SW    = 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [3:0][QuatW-1:0]              quat_i,
  input  logic [LANES-1:0][2:0][VecW-1:0]    vec_i,
  input  logic [SW-1:0]                      side_i,
  output logic                               valid_o,
  output logic [LANES-1:0][2:0][RotW-1:0]    rot_o,
  output logic [SW-1:0]                      side_o
);

  localparam int unsigned ProdW  = QuatW + VecW;
  localparam int unsigned DiffW  = ProdW + 1;
  localparam int unsigned CrsW   = DiffW - 13;
  localparam int unsigned Prod2W = QuatW + CrsW;
  localparam int unsigned SumW   = Prod2W + 2;
  localparam int unsigned FinW   = SumW - 12;

  // Cross product a x v: component i is q[QA]*v[VA] - q[QB]*v[VB]
  localparam int unsigned QA [3] = '{2, 3, 1};
  localparam int unsigned VA [3] = '{2, 0, 1};
  localparam int unsigned QB [3] = '{3, 1, 2};
  localparam int unsigned VB [3] = '{1, 2, 0};

  function automatic logic signed [CrsW-1:0] rnd14(input logic signed [DiffW-1:0] x);
    logic [DiffW-1:0] m;
    logic [DiffW-1:0] r;
    m = x[DiffW-1] ? DiffW'(-x) : DiffW'(x);
    r = (m + DiffW'(1 << 13)) >> 14;
    return x[DiffW-1] ? -CrsW'(r) : CrsW'(r);
  endfunction

  function automatic logic signed [FinW-1:0] rnd13(input logic signed [SumW-1:0] x);
    logic [SumW-1:0] m;
    logic [SumW-1:0] r;
    m = x[SumW-1] ? SumW'(-x) : SumW'(x);
    r = (m + SumW'(1 << 12)) >> 13;
    return x[SumW-1] ? -FinW'(r) : FinW'(r);
  endfunction

  logic [RotStages-1:0]               vld_q;
  logic [SW-1:0]                      side1_q, side2_q, side3_q, side4_q;
  logic [LANES-1:0][2:0][VecW-1:0]    v1_q, v2_q, v3_q;
  logic signed [ProdW-1:0]            pa_q [LANES][3];
  logic signed [ProdW-1:0]            pb_q [LANES][3];
  logic signed [ProdW-1:0]            pa_d [LANES][3];
  logic signed [ProdW-1:0]            pb_d [LANES][3];
  logic signed [CrsW-1:0]             c_q  [LANES][3];
  logic signed [CrsW-1:0]             c_d  [LANES][3];
  logic signed [Prod2W-1:0]           wc_q [LANES][3];
  logic signed [Prod2W-1:0]           sa_q [LANES][3];
  logic signed [Prod2W-1:0]           sb_q [LANES][3];
  logic signed [Prod2W-1:0]           wc_d [LANES][3];
  logic signed [Prod2W-1:0]           sa_d [LANES][3];
  logic signed [Prod2W-1:0]           sb_d [LANES][3];
  logic [LANES-1:0][2:0][RotW-1:0]    rot_d, rot_q;

  // Stage 1: products for the first cross product
  // Stage 2: round the cross product down to the vector scale
  // Stage 3: products for w*c and the second cross product
  // Stage 4: sum, round and add back the input vector
  always_comb begin
    logic signed [FinW:0] tot;
    for (int unsigned l = 0; l < LANES; l++) begin
      for (int unsigned i = 0; i < 3; i++) begin
        pa_d[l][i] = $signed(quat_i[QA[i]]) * $signed(vec_i[l][VA[i]]);
        pb_d[l][i] = $signed(quat_i[QB[i]]) * $signed(vec_i[l][VB[i]]);
        c_d[l][i]  = rnd14(pa_q[l][i] - pb_q[l][i]);
        wc_d[l][i] = $signed(quat_i[0]) * c_q[l][i];
        sa_d[l][i] = $signed(quat_i[QA[i]]) * c_q[l][VA[i]];
        sb_d[l][i] = $signed(quat_i[QB[i]]) * c_q[l][VB[i]];
        tot = $signed(v3_q[l][i]) + rnd13(wc_q[l][i] + sa_q[l][i] - sb_q[l][i]);
        rot_d[l][i] = tot[RotW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[RotStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    side1_q <= side_i;
    side2_q <= side1_q;
    side3_q <= side2_q;
    side4_q <= side3_q;
    v1_q    <= vec_i;
    v2_q    <= v1_q;
    v3_q    <= v2_q;
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    c_q     <= c_d;
    wc_q    <= wc_d;
    sa_q    <= sa_d;
    sb_q    <= sb_d;
    rot_q   <= rot_d;
  end

  assign valid_o = vld_q[RotStages-1];
  assign rot_o   = rot_q;
  assign side_o  = side4_q;

endmodule

/* sv/pointer_ray_unprojection_core.sv */
// Channel   Direction  Handshake                          Payload
// command   in         start_i & !busy_o                  pointer_x_i, pointer_y_i, camera_stale_i
// result    out        result_valid_o, one cycle          status_o, ray_origin_*_o, ray_dir_*_o
// config    in         cfg_valid_i & cfg_ready_o          cfg_index_i, cfg_data_i
//
// A new transaction is taken every cycle; busy_o stays low and cfg_ready_o stays high.
// Each result passes, in order, through the clip divide, scale divide, square root and
// normalize divide (one bit per stage each), then the rotation unit and the glue registers.
// Reset clears the configuration to 1920x1080, unit scales, identity rotation, origin
// at zero and perspective mode, and drops every transaction in flight.
// The result side has no back pressure, so nothing in the pipeline ever stalls.
module pointer_ray_unprojection_core
  import prju_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [15:0]         pointer_x_i,
  input  logic [15:0]         pointer_y_i,
  input  logic                camera_stale_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  output logic                result_valid_o,
  output logic [1:0]          status_o,
  output logic signed [31:0]  ray_origin_x_o,
  output logic signed [31:0]  ray_origin_y_o,
  output logic signed [31:0]  ray_origin_z_o,
  output logic signed [15:0]  ray_dir_x_o,
  output logic signed [15:0]  ray_dir_y_o,
  output logic signed [15:0]  ray_dir_z_o
);

  localparam int unsigned CdivQ = 30;
  localparam int unsigned CdivD = 13;
  localparam int unsigned VdivQ = 32;
  localparam int unsigned VdivD = 32;
  localparam int unsigned SqrtW = 32;
  localparam int unsigned NdivQ = 31;
  localparam int unsigned NdivD = 32;
  localparam int unsigned Latency = CdivQ + VdivQ + SqrtW + NdivQ + RotStages + 6;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] neg;
    logic [1:0] ovf;
  } vside_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } sside_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [2:0]         neg;
  } nside_t;

  // Configuration registers
  logic [23:0]        display_size_q;
  logic signed [31:0] x_scale_q, y_scale_q;
  logic [63:0]        rotation_q;
  logic signed [31:0] camera_pos_x_q, camera_pos_y_q, camera_pos_z_q;
  logic               perspective_mode_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  // Take a configuration transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_size_q     <= 24'd4425600;
      x_scale_q          <= 32'sd65536;
      y_scale_q          <= 32'sd65536;
      rotation_q         <= 64'd16384;
      camera_pos_x_q     <= '0;
      camera_pos_y_q     <= '0;
      camera_pos_z_q     <= '0;
      perspective_mode_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DISPLAY_SIZE: display_size_q     <= cfg_data_i[23:0];
        CFG_X_SCALE:      x_scale_q          <= cfg_data_i[31:0];
        CFG_Y_SCALE:      y_scale_q          <= cfg_data_i[31:0];
        CFG_ROTATION:     rotation_q         <= cfg_data_i;
        CFG_CAM_POS_X:    camera_pos_x_q     <= cfg_data_i[31:0];
        CFG_CAM_POS_Y:    camera_pos_y_q     <= cfg_data_i[31:0];
        CFG_CAM_POS_Z:    camera_pos_z_q     <= cfg_data_i[31:0];
        CFG_PERSPECTIVE:  perspective_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Entry: refusal checks and clip numerators
  logic [11:0] disp_w, disp_h;
  logic [1:0]  status_in;
  logic [1:0][CdivD+CdivQ-1:0] cnum;
  logic [1:0][CdivD-1:0]       cden;

  assign disp_w = display_size_q[11:0];
  assign disp_h = display_size_q[23:12];

  always_comb begin
    if (disp_w == '0 || disp_h == '0) begin
      status_in = ST_NO_EXTENT;
    end else if (camera_stale_i) begin
      status_in = ST_STALE;
    end else if (x_scale_q == '0 || y_scale_q == '0) begin
      status_in = ST_NO_SCALE;
    end else begin
      status_in = ST_OK;
    end
    cnum[0] = (CdivD+CdivQ)'({pointer_x_i, 14'h0}) + (CdivD+CdivQ)'(disp_w);
    cnum[1] = (CdivD+CdivQ)'({pointer_y_i, 14'h0}) + (CdivD+CdivQ)'(disp_h);
    cden[0] = {disp_w, 1'b0};
    cden[1] = {disp_h, 1'b0};
  end

  logic                   cdiv_vld;
  logic [1:0][CdivQ-1:0]  cdiv_quot;
  logic [1:0]             cdiv_status;

  prju_div #(.QW(CdivQ), .DW(CdivD), .LANES(2), .SW(2)) u_clip_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .num_i   (cnum),
    .den_i   (cden),
    .side_i  (status_in),
    .valid_o (cdiv_vld),
    .quot_o  (cdiv_quot),
    .side_o  (cdiv_status)
  );

  // Stage B: clip coordinate to scale-divide operands
  logic                          b_vld_q;
  logic [1:0][VdivD+VdivQ-1:0]   vnum_d, vnum_q;
  logic [1:0][VdivD-1:0]         vden_d, vden_q;
  vside_t                        vside_d, vside_q;

  always_comb begin
    logic signed [30:0] clip;
    logic [29:0]        cmag;
    logic signed [31:0] scale;
    logic [31:0]        smag;
    logic [46:0]        num;
    logic               ovf;
    vside_d.status = cdiv_status;
    for (int unsigned l = 0; l < 2; l++) begin
      clip  = $signed({1'b0, cdiv_quot[l]}) - 31'sd65536;
      cmag  = clip[30] ? 30'(-clip) : clip[29:0];
      scale = (l == 0) ? x_scale_q : y_scale_q;
      smag  = scale[31] ? 32'(-scale) : 32'(scale);
      num   = 47'({cmag, 16'h0}) + 47'(smag[31:1]);
      ovf   = 32'(num[46:32]) >= smag;
      vnum_d[l]      = ovf ? '0 : (VdivD+VdivQ)'(num);
      vden_d[l]      = smag;
      vside_d.neg[l] = clip[30] ^ scale[31];
      vside_d.ovf[l] = ovf;
    end
  end

  logic                  vdiv_vld;
  logic [1:0][VdivQ-1:0] vdiv_quot;
  vside_t                vdiv_side;

  prju_div #(.QW(VdivQ), .DW(VdivD), .LANES(2), .SW($bits(vside_t))) u_view_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_vld_q),
    .num_i   (vnum_q),
    .den_i   (vden_q),
    .side_i  (vside_q),
    .valid_o (vdiv_vld),
    .quot_o  (vdiv_quot),
    .side_o  (vdiv_side)
  );

  // Stage C: signed, saturated view point
  logic                    c_vld_q;
  logic [1:0][31:0]        view_d, view_q;
  logic [1:0]              c_status_q;

  always_comb begin
    for (int unsigned l = 0; l < 2; l++) begin
      if (!vdiv_side.neg[l]) begin
        view_d[l] = (vdiv_side.ovf[l] || vdiv_quot[l][31]) ? 32'h7fff_ffff : vdiv_quot[l];
      end else begin
        view_d[l] = (vdiv_side.ovf[l] || vdiv_quot[l] > 32'h8000_0000) ? 32'h8000_0000
                                                                         : -vdiv_quot[l];
      end
    end
  end

  // Stage D: squares; stage E: sum of squares plus one
  logic               d_vld_q, e_vld_q;
  logic [1:0][63:0]   sq_d, sq_q;
  logic [1:0][31:0]   d_view_q;
  logic [1:0]         d_status_q;
  logic [63:0]        sum_q;
  sside_t             sside_q;

  always_comb begin
    logic [31:0] vmag;
    for (int unsigned l = 0; l < 2; l++) begin
      vmag    = view_q[l][31] ? -view_q[l] : view_q[l];
      sq_d[l] = 64'(vmag) * 64'(vmag);
    end
  end

  logic        sqrt_vld;
  logic [31:0] sqrt_len;
  sside_t      sqrt_side;

  prju_sqrt #(.OW(SqrtW), .SW($bits(sside_t))) u_len_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (e_vld_q),
    .rad_i   (sum_q),
    .side_i  (sside_q),
    .valid_o (sqrt_vld),
    .root_o  (sqrt_len),
    .side_o  (sqrt_side)
  );

  // Stage F: normalize operands, scaled to Q2.30
  logic                          f_vld_q;
  logic [2:0][NdivD+NdivQ-1:0]   nnum_d, nnum_q;
  logic [NdivD-1:0]              nden_q;
  nside_t                        nside_d, nside_q;

  always_comb begin
    logic [31:0] mx, my;
    mx = sqrt_side.vx[31] ? 32'(-sqrt_side.vx) : 32'(sqrt_side.vx);
    my = sqrt_side.vy[31] ? 32'(-sqrt_side.vy) : 32'(sqrt_side.vy);
    nnum_d[0] = (NdivD+NdivQ)'({mx, 30'h0}) + (NdivD+NdivQ)'(sqrt_len[31:1]);
    nnum_d[1] = (NdivD+NdivQ)'({my, 30'h0}) + (NdivD+NdivQ)'(sqrt_len[31:1]);
    nnum_d[2] = (NdivD+NdivQ)'({1'b1, 46'h0}) + (NdivD+NdivQ)'(sqrt_len[31:1]);
    nside_d.status = sqrt_side.status;
    nside_d.vx     = sqrt_side.vx;
    nside_d.vy     = sqrt_side.vy;
    nside_d.neg    = {1'b1, sqrt_side.vy[31], sqrt_side.vx[31]};
  end

  logic                   ndiv_vld;
  logic [2:0][NdivQ-1:0]  ndiv_quot;
  nside_t                 ndiv_side;

  prju_div #(.QW(NdivQ), .DW(NdivD), .LANES(3), .SW($bits(nside_t))) u_norm_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_vld_q),
    .num_i   (nnum_q),
    .den_i   ({3{nden_q}}),
    .side_i  (nside_q),
    .valid_o (ndiv_vld),
    .quot_o  (ndiv_quot),
    .side_o  (ndiv_side)
  );

  // Stage G: pick the vectors to rotate
  logic [2:0][VecW-1:0]      unit_vec, view_vec;
  logic [1:0][2:0][VecW-1:0] rot_in;
  logic [3:0][QuatW-1:0]     quat;

  assign quat = rotation_q;

  always_comb begin
    for (int unsigned i = 0; i < 3; i++) begin
      unit_vec[i] = ndiv_side.neg[i] ? -VecW'(ndiv_quot[i]) : VecW'(ndiv_quot[i]);
    end
    view_vec  = {VecW'(0), ndiv_side.vy, ndiv_side.vx};
    rot_in[0] = perspective_mode_q ? unit_vec : view_vec;
    rot_in[1] = {32'hc000_0000, VecW'(0), VecW'(0)};
  end

  logic                      rot_vld;
  logic [1:0][2:0][RotW-1:0] rot_out;
  logic [1:0]                rot_status;

  prju_rot #(.LANES(2), .SW(2)) u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ndiv_vld),
    .quat_i  (quat),
    .vec_i   (rot_in),
    .side_i  (ndiv_side.status),
    .valid_o (rot_vld),
    .rot_o   (rot_out),
    .side_o  (rot_status)
  );

  // Stage H: round, saturate and mask refused results
  function automatic logic [15:0] dir_sat(input logic [RotW-1:0] r);
    logic [RotW-1:0] m;
    logic [RotW-1:0] t;
    logic [RotW-17:0] q;
    m = r[RotW-1] ? -r : r;
    t = m + RotW'(32768);
    q = t[RotW-1:16];
    if (!r[RotW-1]) begin
      return (q > (RotW-16)'(32767)) ? 16'h7fff : q[15:0];
    end
    return (q > (RotW-16)'(32768)) ? 16'h8000 : -q[15:0];
  endfunction

  function automatic logic [31:0] org_sat(input logic [31:0] p, input logic [RotW-1:0] r);
    logic signed [RotW:0] s;
    s = $signed({{(RotW-31){p[31]}}, p}) + $signed({r[RotW-1], r});
    if (s > $signed((RotW+1)'(32'h7fff_ffff))) begin
      return 32'h7fff_ffff;
    end
    if (s < -$signed((RotW+1)'(33'h0_8000_0000))) begin
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

  logic             out_vld_q;
  logic [1:0]       status_q;
  logic [2:0][31:0] org_d, org_q;
  logic [2:0][15:0] dir_d, dir_q;
  logic [2:0][31:0] cam_pos;

  assign cam_pos = {camera_pos_z_q, camera_pos_y_q, camera_pos_x_q};

  always_comb begin
    for (int unsigned i = 0; i < 3; i++) begin
      if (rot_status != ST_OK) begin
        org_d[i] = '0;
        dir_d[i] = '0;
      end else if (perspective_mode_q) begin
        org_d[i] = cam_pos[i];
        dir_d[i] = dir_sat(rot_out[0][i]);
      end else begin
        org_d[i] = org_sat(cam_pos[i], rot_out[0][i]);
        dir_d[i] = dir_sat(rot_out[1][i]);
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      e_vld_q   <= 1'b0;
      f_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      b_vld_q   <= cdiv_vld;
      c_vld_q   <= vdiv_vld;
      d_vld_q   <= c_vld_q;
      e_vld_q   <= d_vld_q;
      f_vld_q   <= sqrt_vld;
      out_vld_q <= rot_vld;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    vnum_q         <= vnum_d;
    vden_q         <= vden_d;
    vside_q        <= vside_d;
    view_q         <= view_d;
    c_status_q     <= vdiv_side.status;
    sq_q           <= sq_d;
    d_view_q       <= view_q;
    d_status_q     <= c_status_q;
    sum_q          <= sq_q[0] + sq_q[1] + 64'h1_0000_0000;
    sside_q.status <= d_status_q;
    sside_q.vx     <= d_view_q[0];
    sside_q.vy     <= d_view_q[1];
    nnum_q         <= nnum_d;
    nden_q         <= sqrt_len;
    nside_q        <= nside_d;
    status_q       <= rot_status;
    org_q          <= org_d;
    dir_q          <= dir_d;
  end

  assign result_valid_o = out_vld_q;
  assign status_o       = status_q;
  assign ray_origin_x_o = org_q[0];
  assign ray_origin_y_o = org_q[1];
  assign ray_origin_z_o = org_q[2];
  assign ray_dir_x_o    = dir_q[0];
  assign ray_dir_y_o    = dir_q[1];
  assign ray_dir_z_o    = dir_q[2];

`ifndef SYNTHESIS
  a_result_has_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i, Latency))
    else $error("result without a command at the pipeline latency");

  a_stale_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(camera_stale_i, Latency) |-> status_o != ST_OK)
    else $error("stale camera produced an accepted ray");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != ST_OK |->
      ray_origin_x_o == '0 && ray_origin_z_o == '0 && ray_dir_x_o == '0 && ray_dir_z_o == '0)
    else $error("refused result carries a nonzero ray");
`endif

endmodule

/* sim/pointer_ray_unprojection_core_tb.sv */
`timescale 1ns / 1ps

module pointer_ray_unprojection_core_tb;
  import prju_pkg::*;

  localparam int unsigned PipeLatency = 135;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned RandomRays  = 1750;

  // One expected or observed ray
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic signed [31:0] org_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } ray_t;

  // Magnitude helpers on wide signed values
  function automatic logic [127:0] abs128(input logic signed [127:0] x);
    return x < 0 ? -x : x;
  endfunction

  function automatic logic signed [127:0] round_shift(input logic signed [127:0] x,
                                                     input int n);
    logic [127:0] r;
    r = (abs128(x) + (128'd1 << (n - 1))) >> n;
    return x < 0 ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [127:0] round_div(input logic signed [127:0] num,
                                                   input logic signed [127:0] den);
    logic [127:0] d;
    logic [127:0] r;
    d = abs128(den);
    r = (abs128(num) + d / 2) / d;
    return ((num < 0) != (den < 0)) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [127:0] clamp(input logic signed [127:0] x,
                                               input logic signed [127:0] lo,
                                               input logic signed [127:0] hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic logic [127:0] int_sqrt(input logic [127:0] x);
    logic [127:0] res;
    logic [127:0] bitv;
    res  = 0;
    bitv = 128'd1 << 126;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  typedef logic signed [127:0] wide_t;

  // Rotate v by quaternion q (w, i, j, k)
  task automatic quat_rotate(input wide_t q[4], input wide_t v[3], output wide_t o[3]);
    wide_t c[3];
    wide_t s[3];
    c[0] = round_shift(q[2] * v[2] - q[3] * v[1], 14);
    c[1] = round_shift(q[3] * v[0] - q[1] * v[2], 14);
    c[2] = round_shift(q[1] * v[1] - q[2] * v[0], 14);
    s[0] = q[2] * c[2] - q[3] * c[1];
    s[1] = q[3] * c[0] - q[1] * c[2];
    s[2] = q[1] * c[1] - q[2] * c[0];
    for (int i = 0; i < 3; i++) o[i] = v[i] + round_shift(q[0] * c[i] + s[i], 13);
  endtask

  class ray_scoreboard;
    logic [63:0] regs[8];
    ray_t        pending_rays[$];
    int          errors;

    function new();
      regs[CFG_DISPLAY_SIZE] = 64'd4425600;
      regs[CFG_X_SCALE]      = 64'd65536;
      regs[CFG_Y_SCALE]      = 64'd65536;
      regs[CFG_ROTATION]     = 64'd16384;
      regs[CFG_CAM_POS_X]    = 64'd0;
      regs[CFG_CAM_POS_Y]    = 64'd0;
      regs[CFG_CAM_POS_Z]    = 64'd0;
      regs[CFG_PERSPECTIVE]  = 64'd1;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
      case (idx)
        CFG_DISPLAY_SIZE: regs[idx] = data & 64'hFF_FFFF;
        CFG_ROTATION:     regs[idx] = data;
        CFG_PERSPECTIVE:  regs[idx] = data & 64'd1;
        default:          regs[idx] = data & 64'hFFFF_FFFF;
      endcase
    endfunction

    // Work out the ray for one accepted pointer transaction
    task note_pointer(logic [15:0] px, logic [15:0] py, logic stale);
      ray_t  r;
      wide_t w, h, xs, ys, cx, cy, vx, vy, len;
      wide_t q[4];
      wide_t pos[3];
      wide_t v[3];
      wide_t o[3];
      r  = '0;
      w  = wide_t'(regs[CFG_DISPLAY_SIZE][11:0]);
      h  = wide_t'(regs[CFG_DISPLAY_SIZE][23:12]);
      xs = wide_t'($signed(regs[CFG_X_SCALE][31:0]));
      ys = wide_t'($signed(regs[CFG_Y_SCALE][31:0]));
      if (w == 0 || h == 0) begin
        r.status = ST_NO_EXTENT;
      end else if (stale) begin
        r.status = ST_STALE;
      end else if (xs == 0 || ys == 0) begin
        r.status = ST_NO_SCALE;
      end else begin
        r.status = ST_OK;
        cx = (wide_t'(px) * 16384 + w) / (2 * w) - 65536;
        cy = (wide_t'(py) * 16384 + h) / (2 * h) - 65536;
        vx = clamp(round_div(cx * 65536, xs), -(wide_t'(1) << 31), (wide_t'(1) << 31) - 1);
        vy = clamp(round_div(cy * 65536, ys), -(wide_t'(1) << 31), (wide_t'(1) << 31) - 1);
        for (int i = 0; i < 4; i++) q[i] = wide_t'($signed(regs[CFG_ROTATION][16*i +: 16]));
        pos[0] = wide_t'($signed(regs[CFG_CAM_POS_X][31:0]));
        pos[1] = wide_t'($signed(regs[CFG_CAM_POS_Y][31:0]));
        pos[2] = wide_t'($signed(regs[CFG_CAM_POS_Z][31:0]));
        if (regs[CFG_PERSPECTIVE][0]) begin
          len  = $signed(int_sqrt(vx * vx + vy * vy + (wide_t'(1) << 32)));
          v[0] = round_div(vx * (wide_t'(1) << 30), len);
          v[1] = round_div(vy * (wide_t'(1) << 30), len);
          v[2] = round_div(-(wide_t'(1) << 46), len);
          quat_rotate(q, v, o);
          r.org_x = 32'(pos[0]);
          r.org_y = 32'(pos[1]);
          r.org_z = 32'(pos[2]);
        end else begin
          v[0] = vx;
          v[1] = vy;
          v[2] = 0;
          quat_rotate(q, v, o);
          r.org_x = 32'(clamp(pos[0] + o[0], -(wide_t'(1) << 31), (wide_t'(1) << 31) - 1));
          r.org_y = 32'(clamp(pos[1] + o[1], -(wide_t'(1) << 31), (wide_t'(1) << 31) - 1));
          r.org_z = 32'(clamp(pos[2] + o[2], -(wide_t'(1) << 31), (wide_t'(1) << 31) - 1));
          v[0] = 0;
          v[1] = 0;
          v[2] = -(wide_t'(1) << 30);
          quat_rotate(q, v, o);
        end
        r.dir_x = 16'(clamp(round_shift(o[0], 16), -32768, 32767));
        r.dir_y = 16'(clamp(round_shift(o[1], 16), -32768, 32767));
        r.dir_z = 16'(clamp(round_shift(o[2], 16), -32768, 32767));
      end
      pending_rays = {pending_rays, r};
    endtask

    // Compare one observed ray with the oldest pending one
    function void check_ray(ray_t got);
      ray_t exp_ray;
      if (pending_rays.size() == 0) begin
        $display("%0t: unexpected ray, actual %h", $time, got);
        errors++;
        return;
      end
      exp_ray = pending_rays.pop_front();
      if (got.status !== exp_ray.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_ray.status, got.status);
        errors++;
      end
      if (got.org_x !== exp_ray.org_x) begin
        $display("%0t: org_x expected %0d actual %0d", $time, exp_ray.org_x, got.org_x);
        errors++;
      end
      if (got.org_y !== exp_ray.org_y) begin
        $display("%0t: org_y expected %0d actual %0d", $time, exp_ray.org_y, got.org_y);
        errors++;
      end
      if (got.org_z !== exp_ray.org_z) begin
        $display("%0t: org_z expected %0d actual %0d", $time, exp_ray.org_z, got.org_z);
        errors++;
      end
      if (got.dir_x !== exp_ray.dir_x) begin
        $display("%0t: dir_x expected %0d actual %0d", $time, exp_ray.dir_x, got.dir_x);
        errors++;
      end
      if (got.dir_y !== exp_ray.dir_y) begin
        $display("%0t: dir_y expected %0d actual %0d", $time, exp_ray.dir_y, got.dir_y);
        errors++;
      end
      if (got.dir_z !== exp_ray.dir_z) begin
        $display("%0t: dir_z expected %0d actual %0d", $time, exp_ray.dir_z, got.dir_z);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [15:0]        pointer_x_i;
  logic [15:0]        pointer_y_i;
  logic               camera_stale_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [63:0]        cfg_data_i;
  logic               result_valid_o;
  logic [1:0]         status_o;
  logic signed [31:0] ray_origin_x_o;
  logic signed [31:0] ray_origin_y_o;
  logic signed [31:0] ray_origin_z_o;
  logic signed [15:0] ray_dir_x_o;
  logic signed [15:0] ray_dir_y_o;
  logic signed [15:0] ray_dir_z_o;

  ray_scoreboard scb;
  int unsigned   idle_cycles = 0;
  logic          quiet_phase;

  pointer_ray_unprojection_core DUT (.*);

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Check rays and count cycles without progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        scb.check_ray('{status_o, ray_origin_x_o, ray_origin_y_o, ray_origin_z_o,
                        ray_dir_x_o, ray_dir_y_o, ray_dir_z_o});
      end
      if (result_valid_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Write one register through the config channel once nothing is in flight
  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
    start_i <= 1'b0;
    while (scb.pending_rays.size() != 0) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    scb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Send one pointer transaction, optionally preceded by a random gap
  task automatic send_pointer(logic [15:0] px, logic [15:0] py, logic stale);
    if (!quiet_phase) begin
      while ($urandom_range(99) < 17) begin
        start_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    start_i        <= 1'b1;
    pointer_x_i    <= px;
    pointer_y_i    <= py;
    camera_stale_i <= stale;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    scb.note_pointer(px, py, stale);
    @(negedge clk_i);
  endtask

  // Let the pipeline empty before touching registers
  task automatic drain();
    start_i <= 1'b0;
    while (scb.pending_rays.size() != 0) @(negedge clk_i);
    repeat (PipeLatency + 5) @(negedge clk_i);
  endtask

  task automatic random_pointer();
    logic [15:0] px;
    logic [15:0] py;
    px = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2 * 16 * 2048));
    py = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2 * 16 * 2048));
    send_pointer(px, py, $urandom_range(15) == 0);
  endtask

  // Pick a mostly unit-ish quaternion, sometimes arbitrary
  function automatic logic [63:0] random_quat();
    if ($urandom_range(3) == 0) return {$urandom, $urandom};
    return {16'($signed($urandom_range(8192)) - 4096), 16'($signed($urandom_range(8192)) - 4096),
            16'($signed($urandom_range(8192)) - 4096), 16'($urandom_range(16384, 12000))};
  endfunction

  function automatic logic [31:0] random_scale();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(64)) - 32);
      default: return 32'($signed($urandom_range(4 * 65536, 16384)) *
                          ($urandom_range(1) ? 1 : -1));
    endcase
  endfunction

  initial begin
    scb            = new();
    quiet_phase    = 1'b0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    pointer_x_i    = '0;
    pointer_y_i    = '0;
    camera_stale_i = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_DISPLAY_SIZE;
    cfg_data_i     = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset configuration, corners, center, beyond extent, stale
    send_pointer(16'd0, 16'd0, 1'b0);
    send_pointer(16'hFFFF, 16'hFFFF, 1'b0);
    send_pointer(16'd15360, 16'd8640, 1'b0);
    send_pointer(16'd30720, 16'd17280, 1'b0);
    send_pointer(16'h5555, 16'hAAAA, 1'b0);
    send_pointer(16'hAAAA, 16'h5555, 1'b1);
    drain();

    // Directed: parallel mode, tiny scale saturation, odd quaternion
    write_cfg(CFG_PERSPECTIVE, 64'd0);
    write_cfg(CFG_X_SCALE, 64'd1);
    write_cfg(CFG_Y_SCALE, 64'hFFFF_FFFF);
    write_cfg(CFG_ROTATION, 64'h7FFF_8000_7FFF_8000);
    write_cfg(CFG_CAM_POS_X, 64'h7FFF_FFFF);
    write_cfg(CFG_CAM_POS_Y, 64'h8000_0000);
    write_cfg(CFG_CAM_POS_Z, 64'h1234_5678);
    send_pointer(16'd0, 16'hFFFF, 1'b0);
    send_pointer(16'hFFFF, 16'd0, 1'b0);
    send_pointer(16'd15360, 16'd8640, 1'b0);
    write_cfg(CFG_PERSPECTIVE, 64'd1);
    send_pointer(16'd0, 16'hFFFF, 1'b0);
    send_pointer(16'h1234, 16'h4321, 1'b0);
    drain();

    // Directed: refusals in priority order
    write_cfg(CFG_X_SCALE, 64'd0);
    send_pointer(16'd100, 16'd100, 1'b0);
    send_pointer(16'd100, 16'd100, 1'b1);
    write_cfg(CFG_DISPLAY_SIZE, 64'hFFF000);
    send_pointer(16'd100, 16'd100, 1'b1);
    write_cfg(CFG_DISPLAY_SIZE, 64'h000FFF);
    send_pointer(16'd100, 16'd100, 1'b0);
    write_cfg(CFG_DISPLAY_SIZE, 64'hFFFFFF);
    write_cfg(CFG_X_SCALE, 64'h7FFF_FFFF);
    write_cfg(CFG_Y_SCALE, 64'h8000_0000);
    send_pointer(16'hFFFF, 16'd0, 1'b0);
    write_cfg(CFG_DISPLAY_SIZE, 64'h001001);
    send_pointer(16'hFFFF, 16'hFFFF, 1'b0);
    drain();

    // Random phases with fresh settings; one phase with no gaps
    for (int phase = 0; phase < 14; phase++) begin
      quiet_phase = (phase == 3);
      write_cfg(CFG_DISPLAY_SIZE, $urandom_range(15) == 0 ? 64'($urandom) :
                {40'd0, 12'($urandom_range(4095, 1)), 12'($urandom_range(4095, 1))});
      write_cfg(CFG_X_SCALE, 64'(random_scale()));
      write_cfg(CFG_Y_SCALE, 64'(random_scale()));
      write_cfg(CFG_ROTATION, random_quat());
      write_cfg(CFG_CAM_POS_X, 64'($urandom));
      write_cfg(CFG_CAM_POS_Y, 64'($urandom));
      write_cfg(CFG_CAM_POS_Z, 64'($urandom));
      write_cfg(CFG_PERSPECTIVE, 64'(phase % 2));
      if ($urandom_range(7) == 0) write_cfg(CfgIdxW'($urandom_range(7)), {$urandom, $urandom});
      for (int n = 0; n < RandomRays / 14; n++) random_pointer();
      drain();
    end

    // Final wait for stragglers
    start_i <= 1'b0;
    repeat (PipeLatency + 10) @(negedge clk_i);
    if (scb.errors == 0 && scb.pending_rays.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
